// ===== rtl/bps_pkg.sv =====
package bps_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int WIN_DEPTH   = MAX_PATTERN + 3;
    localparam int CNT_W       = $clog2(WIN_DEPTH + 1);
    localparam int IDX_W       = $clog2(WIN_DEPTH);
    localparam int CAP_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W       = 5;
    localparam int REG_ENTRIES = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [1:0] KIND_EQUAL = 2'd0;
    localparam logic [1:0] KIND_BELOW = 2'd1;
    localparam logic [1:0] KIND_ABOVE = 2'd2;
    localparam logic [1:0] KIND_ANY   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_KINDS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUES_LOW     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUES_HIGH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_MODE    = 3'd4;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [31:0] byte_address;
        logic        region_start;
    } t_in;

    typedef struct packed {
        logic [31:0] found_value;
        logic [31:0] match_start;
    } t_out;

    typedef struct packed {
        logic [LEN_W-1:0] pattern_length;
        logic [31:0]      compare_kinds;
        logic [63:0]      values_low;
        logic [63:0]      values_high;
        logic             report_mode;
    } t_cfg;

    typedef logic [WIN_DEPTH-1:0][7:0] t_window;

    // Entries without register bits read as kind any, value zero.
    function automatic logic [1:0] entry_kind(input t_cfg cfg, input int p);
        logic [1:0] k;
        k = KIND_ANY;
        if (p < REG_ENTRIES) begin
            k = cfg.compare_kinds[2*(p % REG_ENTRIES) +: 2];
        end
        return k;
    endfunction

    function automatic logic [7:0] entry_value(input t_cfg cfg, input int p);
        logic [7:0] v;
        v = 8'h00;
        if (p < 8) begin
            v = cfg.values_low[8*(p % 8) +: 8];
        end else if (p < REG_ENTRIES) begin
            v = cfg.values_high[8*(p % 8) +: 8];
        end
        return v;
    endfunction

endpackage

// ===== rtl/bps_judge.sv =====
module bps_judge (
    input  bps_pkg::t_window          i_window,
    input  logic [bps_pkg::CNT_W-1:0] i_fill,
    input  logic [31:0]               i_addr,
    input  bps_pkg::t_cfg             i_cfg,
    output logic                      o_hit,
    output bps_pkg::t_out             o_result
);
    import bps_pkg::*;

    logic [CNT_W-1:0] len;
    logic [CAP_W-1:0] cap;
    logic [CNT_W-1:0] span;
    logic [CNT_W-1:0] cap_plus4;
    logic [IDX_W-1:0] age;
    logic [31:0]      start;
    logic             all_ok;

    function automatic logic [7:0] win_at(input t_window w, input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (32'(idx) < WIN_DEPTH) begin
            b = w[idx];
        end
        return b;
    endfunction

    always_comb begin
        // clamp length into 1..MAX_PATTERN
        len = CNT_W'(i_cfg.pattern_length);
        if (len == '0) begin
            len = CNT_W'(1);
        end
        if (32'(len) > MAX_PATTERN) begin
            len = CNT_W'(MAX_PATTERN);
        end

        // descending scan leaves the lowest qualifying entry
        cap = '0;
        for (int p = MAX_PATTERN - 1; p >= 0; p--) begin
            if (p < 32'(len) && entry_kind(i_cfg, p) == KIND_ANY
                    && entry_value(i_cfg, p) == 8'h00) begin
                cap = CAP_W'(p);
            end
        end

        cap_plus4 = CNT_W'(cap) + CNT_W'(4);
        span = len;
        if (i_cfg.report_mode && cap_plus4 > span) begin
            span = cap_plus4;
        end

        all_ok = 1'b1;
        for (int p = 0; p < MAX_PATTERN; p++) begin
            logic [IDX_W-1:0] idx;
            logic [7:0]       b;
            logic [7:0]       v;
            logic             ok;
            idx = IDX_W'(span - CNT_W'(1) - CNT_W'(p));
            b   = win_at(i_window, idx);
            v   = entry_value(i_cfg, p);
            case (entry_kind(i_cfg, p))
                KIND_EQUAL: ok = (b == v);
                KIND_BELOW: ok = (b < v);
                KIND_ABOVE: ok = (b > v);
                default:    ok = 1'b1;
            endcase
            if (p < 32'(len) && !ok) begin
                all_ok = 1'b0;
            end
        end

        start = i_addr - 32'(span) + 32'd1;
        age   = IDX_W'(span - CNT_W'(1) - CNT_W'(cap));

        o_hit = all_ok && (i_fill >= span);
        o_result.match_start = start;
        if (i_cfg.report_mode) begin
            o_result.found_value = {win_at(i_window, age - IDX_W'(3)),
                                    win_at(i_window, age - IDX_W'(2)),
                                    win_at(i_window, age - IDX_W'(1)),
                                    win_at(i_window, age)};
        end else begin
            o_result.found_value = start + 32'(cap);
        end
    end

endmodule

// ===== rtl/byte_pattern_scanner_top.sv =====
// A byte is registered into the window stage, then its judgement is registered into the output register.
// Throughput: one byte per cycle; the window shift register and the parallel entry
// comparators take a new byte each cycle while the output register is free or being taken.
// Reset (synchronous, active low) empties the window and pipeline and loads the
// register defaults: length 1, all kinds any, values zero, address mode.
module byte_pattern_scanner_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  bps_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output bps_pkg::t_out                 o_out_data,
    input  logic                          i_cfg_we,
    input  logic [bps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bps_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bps_pkg::*;

    t_cfg             r_cfg;
    t_window          r_win;
    logic [CNT_W-1:0] r_fill;
    logic [31:0]      r_addr;
    logic             r_s1_valid;
    logic             r_out_valid;
    t_out             r_out_data;

    t_window          n_win;
    logic [CNT_W-1:0] n_fill;
    logic             in_take;
    logic             s1_move;
    logic             hit;
    t_out             result;

    assign s1_move    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_move;
    assign in_take    = i_in_valid && o_in_ready;

    always_comb begin
        logic [CNT_W-1:0] base;
        // bytes past the fill count are never compared, so only the count clears
        n_win = {r_win[WIN_DEPTH-2:0], i_in_data.data_byte};
        base  = i_in_data.region_start ? '0 : r_fill;
        n_fill = base;
        if (32'(base) < WIN_DEPTH) begin
            n_fill = base + CNT_W'(1);
        end
    end

    bps_judge u_judge (
        .i_window (r_win),
        .i_fill   (r_fill),
        .i_addr   (r_addr),
        .i_cfg    (r_cfg),
        .o_hit    (hit),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_length <= LEN_W'(1);
            r_cfg.compare_kinds  <= '1;
            r_cfg.values_low     <= '0;
            r_cfg.values_high    <= '0;
            r_cfg.report_mode    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PATTERN_LENGTH: r_cfg.pattern_length <= i_cfg_data[LEN_W-1:0];
                CFG_COMPARE_KINDS:  r_cfg.compare_kinds  <= i_cfg_data[31:0];
                CFG_VALUES_LOW:     r_cfg.values_low     <= i_cfg_data;
                CFG_VALUES_HIGH:    r_cfg.values_high    <= i_cfg_data;
                CFG_REPORT_MODE:    r_cfg.report_mode    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_fill     <= n_fill;
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            // drop the result slot once taken unless a new judgement lands
            if (s1_move) begin
                r_out_valid <= hit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_win  <= n_win;
            r_addr <= i_in_data.byte_address;
        end
        if (s1_move) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== bench/tb_byte_pattern_scanner_top.sv =====
module tb_byte_pattern_scanner_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bps_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int unsigned DRAIN_CYCLES = 4;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in                   i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out                  o_out_data;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Scanner state as predicted, plus the register copy it works from.
    logic [7:0]    scan_window [WIN_DEPTH];
    int unsigned   window_fill = 0;
    logic [LEN_W-1:0] cfg_len  = 5'd1;
    logic [31:0]   cfg_kinds   = 32'hFFFF_FFFF;
    logic [127:0]  cfg_vals    = '0;
    logic          cfg_word    = 1'b0;

    t_out          expected_hits [$];
    t_out          hit_want;
    int unsigned   error_count = 0;
    int unsigned   bytes_sent  = 0;
    int unsigned   cycle_count;
    int unsigned   send_idle_pct  = 0;
    int unsigned   take_stall_pct = 0;
    logic [31:0]   next_addr      = '0;
    logic          region_pending = 1'b1;

    byte_pattern_scanner_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        foreach (scan_window[i]) scan_window[i] = 8'h00;
    end

    function automatic int unsigned clamp_length(input logic [LEN_W-1:0] raw);
        int unsigned len;
        len = raw;
        if (len < 1) len = 1;
        if (len > MAX_PATTERN) len = MAX_PATTERN;
        return len;
    endfunction

    function automatic logic [1:0] kind_at(input int unsigned p);
        if (p < 16) return cfg_kinds[2*p +: 2];
        return KIND_ANY;
    endfunction

    function automatic logic [7:0] value_at(input int unsigned p);
        if (p < 16) return cfg_vals[8*p +: 8];
        return 8'h00;
    endfunction

    function automatic int unsigned capture_index(input int unsigned len);
        for (int unsigned p = 0; p < len; p++) begin
            if (kind_at(p) == KIND_ANY && value_at(p) == 8'h00) return p;
        end
        return 0;
    endfunction

    function automatic int unsigned window_span(input int unsigned len, input int unsigned cap);
        int unsigned span;
        span = len;
        if (cfg_word && cap + 4 > span) span = cap + 4;
        return span;
    endfunction

    // Shift one byte into the predicted window and queue the report it causes.
    function automatic void scan_byte(input t_in item);
        int unsigned len, cap, span, age;
        logic [7:0]  b, v;
        bit          hit;
        t_out        res;
        if (item.region_start) begin
            foreach (scan_window[i]) scan_window[i] = 8'h00;
            window_fill = 0;
        end
        for (int i = WIN_DEPTH - 1; i > 0; i--) scan_window[i] = scan_window[i-1];
        scan_window[0] = item.data_byte;
        if (window_fill < WIN_DEPTH) window_fill++;
        len  = clamp_length(cfg_len);
        cap  = capture_index(len);
        span = window_span(len, cap);
        if (window_fill < span) return;
        hit = 1'b1;
        for (int unsigned p = 0; p < len; p++) begin
            b = scan_window[span - 1 - p];
            v = value_at(p);
            case (kind_at(p))
                KIND_EQUAL: if (b != v) hit = 1'b0;
                KIND_BELOW: if (!(b < v)) hit = 1'b0;
                KIND_ABOVE: if (!(b > v)) hit = 1'b0;
                default: ;
            endcase
        end
        if (!hit) return;
        res.match_start = item.byte_address - 32'(span - 1);
        if (cfg_word) begin
            age = span - 1 - cap;
            res.found_value = {scan_window[age-3], scan_window[age-2],
                               scan_window[age-1], scan_window[age]};
        end else begin
            res.found_value = res.match_start + 32'(cap);
        end
        expected_hits.insert(expected_hits.size(), res);
    endfunction

    function automatic logic [7:0] passing_byte(input logic [1:0] kind, input logic [7:0] v);
        logic [7:0] b;
        b = 8'($urandom_range(255));
        case (kind)
            KIND_EQUAL: b = v;
            KIND_BELOW: if (v != 8'h00) begin
                b = ($urandom_range(3) == 0) ? v - 8'd1 : 8'($urandom_range(v - 1));
            end
            KIND_ABOVE: if (v != 8'hFF) begin
                b = ($urandom_range(3) == 0) ? v + 8'd1 : 8'($urandom_range(255, v + 1));
            end
            default: ;
        endcase
        return b;
    endfunction

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= take_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_hits.size() == 0) begin
                $display("%0t: unexpected report, expected none, got %08h/%08h", $time,
                         o_out_data.found_value, o_out_data.match_start);
                error_count++;
            end else begin
                hit_want = expected_hits.pop_front();
                if (o_out_data.found_value !== hit_want.found_value) begin
                    $display("%0t: found_value expected %08h, got %08h", $time,
                             hit_want.found_value, o_out_data.found_value);
                    error_count++;
                end
                if (o_out_data.match_start !== hit_want.match_start) begin
                    $display("%0t: match_start expected %08h, got %08h", $time,
                             hit_want.match_start, o_out_data.match_start);
                    error_count++;
                end
            end
        end
    end

    task automatic start_region(input logic [31:0] addr);
        next_addr      = addr;
        region_pending = 1'b1;
    endtask

    task automatic new_region();
        if ($urandom_range(3) == 0) start_region(32'hFFFF_FFFF - $urandom_range(24));
        else start_region($urandom);
    endtask

    task automatic send_byte(input logic [7:0] data);
        t_in item;
        item.data_byte    = data;
        item.byte_address = next_addr;
        item.region_start = region_pending;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        scan_byte(item);
        next_addr      = next_addr + 32'd1;
        region_pending = 1'b0;
        bytes_sent++;
    endtask

    // Drop valid, drain every pending report, then let the pipeline empty.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_hits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_pattern(input logic [63:0] len_word, kinds_word,
                                input logic [127:0] vals, input logic [63:0] mode_word);
        logic [CFG_IDX_W-1:0]  reg_index [5];
        logic [CFG_DATA_W-1:0] reg_data  [5];
        settle();
        reg_index = '{CFG_PATTERN_LENGTH, CFG_COMPARE_KINDS, CFG_VALUES_LOW,
                      CFG_VALUES_HIGH, CFG_REPORT_MODE};
        reg_data  = '{len_word, kinds_word, vals[63:0], vals[127:64], mode_word};
        for (int r = 0; r < 5; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= reg_index[r];
            i_cfg_data  <= reg_data[r];
            @(posedge i_clk);
        end
        i_cfg_we  <= 1'b0;
        cfg_len   = len_word[LEN_W-1:0];
        cfg_kinds = kinds_word[31:0];
        cfg_vals  = vals;
        cfg_word  = mode_word[0];
    endtask

    // style 1: sixteen equal-zero entries; style 2: clamped length, all any 0xFF, word mode.
    task automatic load_random_pattern(input int style);
        logic [63:0]  len_word, kinds_word, mode_word;
        logic [127:0] vals;
        int unsigned  len, cap;
        len_word   = {$urandom, $urandom};
        kinds_word = {$urandom, $urandom};
        mode_word  = {$urandom, $urandom};
        vals       = {$urandom, $urandom, $urandom, $urandom};
        case (style)
            1: begin
                len_word[4:0]    = 5'd16;
                kinds_word[31:0] = {16{KIND_EQUAL}};
                vals             = '0;
            end
            2: begin
                len_word[4:0]    = 5'd31;
                kinds_word[31:0] = {16{KIND_ANY}};
                vals             = '1;
                mode_word[0]     = 1'b1;
            end
            default: begin
                case ($urandom_range(9))
                    0:       len_word[4:0] = 5'd0;
                    1:       len_word[4:0] = 5'($urandom_range(31, 17));
                    2:       len_word[4:0] = 5'd16;
                    default: len_word[4:0] = 5'($urandom_range(16, 1));
                endcase
                // Keep most entries satisfiable.
                for (int p = 0; p < 16; p++) begin
                    if (kinds_word[2*p +: 2] == KIND_BELOW && vals[8*p +: 8] == 8'h00
                            && $urandom_range(3) != 0) begin
                        vals[8*p +: 8] = 8'($urandom_range(255, 1));
                    end
                    if (kinds_word[2*p +: 2] == KIND_ABOVE && vals[8*p +: 8] == 8'hFF
                            && $urandom_range(3) != 0) begin
                        vals[8*p +: 8] = 8'($urandom_range(254));
                    end
                end
                if ($urandom_range(9) < 6) begin
                    len = clamp_length(len_word[4:0]);
                    cap = $urandom_range(len - 1);
                    kinds_word[2*cap +: 2] = KIND_ANY;
                    vals[8*cap +: 8]       = 8'h00;
                end
            end
        endcase
        load_pattern(len_word, kinds_word, vals, mode_word);
    endtask

    // Send bytes that satisfy the pattern; a broken plant stops early and jumps region.
    task automatic plant_match(input bit broken);
        int unsigned len, cap, span, count;
        len   = clamp_length(cfg_len);
        cap   = capture_index(len);
        span  = window_span(len, cap);
        count = broken ? $urandom_range(span - 1) : span;
        for (int unsigned p = 0; p < count; p++) begin
            send_byte(p < len ? passing_byte(kind_at(p), value_at(p)) : 8'($urandom_range(255)));
        end
        if (broken) new_region();
    endtask

    task automatic test_reset_defaults();
        start_region(32'hFFFF_FFFE);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);
    endtask

    task automatic test_compare_kinds();
        logic [7:0] seq [8] = '{8'hAA, 8'h0F, 8'hF1, 8'h33, 8'hAA, 8'h10, 8'hF0, 8'h00};
        // entries: equal 0xAA, below 0x10, above 0xF0, any zero (capture at 3)
        load_pattern(64'd4, 64'hFFFF_FFE4, 128'h00F0_10AA, 64'd0);
        start_region(32'h0000_1000);
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    task automatic test_word_capture();
        logic [7:0] seq [5] = '{8'h55, 8'h11, 8'h22, 8'h33, 8'h44};
        load_pattern(64'd2, 64'hFFFF_FFFC, 128'h0055, 64'd1);
        start_region(32'hFFFF_FFFD);
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    task automatic test_region_clear();
        load_pattern(64'd3, 64'hFFFF_FFFF, 128'h01_0101, 64'd0);
        start_region(32'h8000_0000);
        send_byte(8'h11);
        send_byte(8'h22);
        start_region(32'h7FFF_FFF0);
        send_byte(8'h33);
        send_byte(8'h44);
        send_byte(8'h55);
    endtask

    task automatic test_random_scan(input int unsigned n_items, input int unsigned sender_idle,
                                    input int unsigned receiver_stall, input int first_style);
        int unsigned stop_at, batch_end;
        int          style;
        send_idle_pct  = sender_idle;
        take_stall_pct = receiver_stall;
        style   = first_style;
        stop_at = bytes_sent + n_items;
        while (bytes_sent < stop_at) begin
            load_random_pattern(style);
            style = 0;
            if ($urandom_range(3) != 0) new_region();
            batch_end = bytes_sent + 50;
            while (bytes_sent < batch_end && bytes_sent < stop_at) begin
                case ($urandom_range(19))
                    0, 1:          new_region();
                    2:             plant_match(1'b1);
                    3, 4, 5, 6, 7: repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(255)));
                    default:       plant_match(1'b0);
                endcase
            end
        end
    endtask

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_compare_kinds();
        test_word_capture();
        test_region_clear();
        test_random_scan(280, 0, 0, 1);
        test_random_scan(280, 81, 0, 2);
        test_random_scan(280, 0, 81, 0);
        test_random_scan(280, 38, 38, 0);
        settle();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
